// ===== rtl/pqhs_pkg.sv =====
// Shared types and constants for the play queue with history stack.
package pqhs_pkg;

    // Number of entries in the play queue and in the history stack.
    localparam int DEPTH    = 1024;

    localparam int KIND_W   = 2;
    localparam int ENTRY_W  = 16;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COUNT_W  = $clog2(DEPTH + 1);

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam kind_t KIND_ADD  = 2'd0;
    localparam kind_t KIND_NEXT = 2'd1;
    localparam kind_t KIND_PREV = 2'd2;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_QFULL   = 3'd1;
    localparam status_t ST_QEMPTY  = 3'd2;
    localparam status_t ST_HEMPTY  = 3'd3;
    localparam status_t ST_DROPPED = 3'd4;

endpackage

// ===== rtl/pqhs_req_if.sv =====
// Request channel: one operation transfer with its kind and entry handle.
interface pqhs_req_if import pqhs_pkg::*;;

    logic   valid;
    logic   ready;
    kind_t  kind;
    entry_t entry_in;

    modport source (output valid, output kind, output entry_in, input ready);
    modport sink   (input valid, input kind, input entry_in, output ready);

endinterface

// ===== rtl/pqhs_rsp_if.sv =====
// Response channel: one result transfer per operation.
interface pqhs_rsp_if import pqhs_pkg::*;;

    logic    valid;
    logic    ready;
    entry_t  entry_out;
    status_t status;
    count_t  queue_count;
    count_t  history_count;

    modport source (output valid, output entry_out, output status,
                    output queue_count, output history_count, input ready);
    modport sink   (input valid, input entry_out, input status,
                    input queue_count, input history_count, output ready);

endinterface

// ===== rtl/pqhs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pqhs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read returns the old contents when it hits the address being written.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/play_queue_with_history_stack.sv =====
// Play queue with history stack: a circular FIFO of entry handles plus a LIFO history.
//
// Each request transfer carries one operation: add appends entry_in to the FIFO, next moves
// the FIFO head onto the history stack and returns it, previous pops the history top,
// returns it and appends it to the FIFO again. Every operation produces exactly one
// response transfer with the moved entry (zero when none), a status code and both
// occupancies after the operation. The block takes one request per clock cycle while
// req.ready is high. The request transfer updates the pointers and counts and starts the
// read of the FIFO or stack RAM into the middle stage, which then takes the registered
// read data into the response register. A stalled response holds the request
// side only once both the middle stage and the response register are full. Both stores
// are DEPTH entries deep, with DEPTH and the entry width fixed in the package. Both stores
// are plain RAMs with no reset and no clearing pass; nothing is ever read before it has
// been written. The kind code 3 is a no-op that reports OK and the current counts.
module play_queue_with_history_stack import pqhs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    pqhs_req_if.sink   req,
    pqhs_rsp_if.source rsp
);

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] cnt_t;
    typedef logic [ENTRY_W-1:0] word_t;

    // Architectural pointers and counts, updated at the request transfer.
    addr_t q_head_reg, q_head_next;
    addr_t q_tail_reg, q_tail_next;
    cnt_t  q_fill_reg, q_fill_next;
    cnt_t  h_fill_reg, h_fill_next;

    // Middle stage: waits for the RAM read data, then writes the moved entry.
    logic    s1_valid_reg;
    logic    s1_src_q_reg, s1_src_h_reg;
    logic    s1_wr_q_reg, s1_wr_h_reg;
    addr_t   s1_waddr_reg;
    word_t   s1_add_data_reg;
    logic    s1_fwd_reg;
    word_t   s1_fwd_data_reg;
    status_t s1_status_reg;
    cnt_t    s1_qcnt_reg, s1_hcnt_reg;

    // Response register.
    logic    out_valid_reg;
    entry_t  out_entry_reg;
    status_t out_status_reg;
    count_t  out_qcnt_reg, out_hcnt_reg;

    // Decode of the incoming operation.
    logic    accept;
    logic    s1_adv;
    logic    rd_q, rd_h;
    logic    wr_q, wr_h;
    addr_t   raddr;
    addr_t   waddr;
    status_t status_next;
    logic    fwd;

    // RAM ports.
    logic  q_we, h_we;
    word_t q_rdata, h_rdata;
    word_t s1_moved;
    word_t s1_wdata;

    function automatic addr_t wrap_next(input addr_t idx);
        return (idx == addr_t'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // The middle stage moves on when the response register is free or drains this cycle.
    assign s1_adv   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept   = req.valid && req.ready;

    always_comb
    begin
        q_head_next = q_head_reg;
        q_tail_next = q_tail_reg;
        q_fill_next = q_fill_reg;
        h_fill_next = h_fill_reg;
        rd_q        = 1'b0;
        rd_h        = 1'b0;
        wr_q        = 1'b0;
        wr_h        = 1'b0;
        raddr       = q_head_reg;
        waddr       = q_tail_reg;
        status_next = ST_OK;
        case (req.kind)
            KIND_ADD:
            begin
                if (q_fill_reg == cnt_t'(DEPTH))
                begin
                    status_next = ST_QFULL;
                end
                else
                begin
                    wr_q        = 1'b1;
                    waddr       = q_tail_reg;
                    q_tail_next = wrap_next(q_tail_reg);
                    q_fill_next = q_fill_reg + 1'b1;
                end
            end
            KIND_NEXT:
            begin
                if (q_fill_reg == '0)
                begin
                    status_next = ST_QEMPTY;
                end
                else
                begin
                    rd_q        = 1'b1;
                    raddr       = q_head_reg;
                    q_head_next = wrap_next(q_head_reg);
                    q_fill_next = q_fill_reg - 1'b1;
                    if (h_fill_reg == cnt_t'(DEPTH))
                    begin
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        wr_h        = 1'b1;
                        waddr       = h_fill_reg[ADDR_W-1:0];
                        h_fill_next = h_fill_reg + 1'b1;
                    end
                end
            end
            KIND_PREV:
            begin
                if (h_fill_reg == '0)
                begin
                    status_next = ST_HEMPTY;
                end
                else
                begin
                    rd_h        = 1'b1;
                    h_fill_next = h_fill_reg - 1'b1;
                    raddr       = h_fill_next[ADDR_W-1:0];
                    if (q_fill_reg == cnt_t'(DEPTH))
                    begin
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        wr_q        = 1'b1;
                        waddr       = q_tail_reg;
                        q_tail_next = wrap_next(q_tail_reg);
                        q_fill_next = q_fill_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // The middle stage writes its entry at the same edge at which a new read starts, and
    // the RAM returns old data then, so a read of that very address takes the value here.
    assign fwd = s1_valid_reg &&
                 ((rd_q && s1_wr_q_reg && (s1_waddr_reg == raddr)) ||
                  (rd_h && s1_wr_h_reg && (s1_waddr_reg == raddr)));

    assign s1_moved = s1_fwd_reg   ? s1_fwd_data_reg :
                      s1_src_q_reg ? q_rdata : h_rdata;
    assign s1_wdata = (s1_src_q_reg || s1_src_h_reg) ? s1_moved : s1_add_data_reg;

    assign q_we = s1_valid_reg && s1_adv && s1_wr_q_reg;
    assign h_we = s1_valid_reg && s1_adv && s1_wr_h_reg;

    pqhs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (s1_waddr_reg),
        .wdata (s1_wdata),
        .re    (accept && rd_q),
        .raddr (raddr),
        .rdata (q_rdata)
    );

    pqhs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_history_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (s1_waddr_reg),
        .wdata (s1_wdata),
        .re    (accept && rd_h),
        .raddr (raddr),
        .rdata (h_rdata)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg    <= '0;
            q_tail_reg    <= '0;
            q_fill_reg    <= '0;
            h_fill_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                q_head_reg <= q_head_next;
                q_tail_reg <= q_tail_next;
                q_fill_reg <= q_fill_next;
                h_fill_reg <= h_fill_next;
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload of the middle stage and of the response register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_q_reg    <= rd_q;
            s1_src_h_reg    <= rd_h;
            s1_wr_q_reg     <= wr_q;
            s1_wr_h_reg     <= wr_h;
            s1_waddr_reg    <= waddr;
            s1_add_data_reg <= req.entry_in;
            s1_fwd_reg      <= fwd;
            s1_fwd_data_reg <= s1_wdata;
            s1_status_reg   <= status_next;
            s1_qcnt_reg     <= q_fill_next;
            s1_hcnt_reg     <= h_fill_next;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_entry_reg  <= (s1_src_q_reg || s1_src_h_reg) ? s1_moved : '0;
            out_status_reg <= s1_status_reg;
            out_qcnt_reg   <= s1_qcnt_reg;
            out_hcnt_reg   <= s1_hcnt_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.entry_out     = out_entry_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.queue_count   = out_qcnt_reg;
    assign rsp.history_count = out_hcnt_reg;

    // An operation moves an entry into at most one store, so the two RAMs never write
    // together.
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_we && h_we))
        else $error("both stores written in one cycle");

    // Neither occupancy may pass the store depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (q_fill_reg <= cnt_t'(DEPTH)) && (h_fill_reg <= cnt_t'(DEPTH)))
        else $error("occupancy beyond depth");

    // An empty or full FIFO has its head and tail pointers on the same slot.
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        ((q_fill_reg == '0) || (q_fill_reg == cnt_t'(DEPTH))) |-> (q_head_reg == q_tail_reg))
        else $error("queue pointers disagree with occupancy");

    // A request transfer always reaches the middle stage in the next cycle.
    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted operation lost before the middle stage");

endmodule
